>>> hdl/min_tracking_stack_unit_macros.svh
// Assertion macros shared by the min tracking stack checker.
`ifndef MIN_TRACKING_STACK_UNIT_MACROS_SVH
`define MIN_TRACKING_STACK_UNIT_MACROS_SVH

// Check a property on the rising clock edge, ignored while reset is held.
`define MTS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on the rising clock edge, during reset as well.
`define MTS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hdl/mts_pkg.sv
// Shared constants and types of the min tracking stack.
`default_nettype none
package mts_pkg;

  localparam int STACK_DEPTH = 256;
  localparam int DATA_W      = 32;
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

  localparam logic [DATA_W-1:0] INT_MAX = {1'b0, {(DATA_W-1){1'b1}}};

  // Operation codes carried on the input tuser bit
  localparam logic REQ_PUSH = 1'b0;
  localparam logic REQ_POP  = 1'b1;

  // Shift command broadcast to every cell of a lane
  typedef struct packed {
    logic push;  // every cell takes its upper neighbor, top cell takes new data
    logic pop;   // every cell takes its lower neighbor
  } shift_ctl_t;

endpackage
`default_nettype wire

>>> hdl/mts_cell.sv
// One stack entry: a data register that shifts toward or away from the top.
`default_nettype none
module mts_cell (
  input  wire logic                       clk,
  input  wire mts_pkg::shift_ctl_t        ctl,
  input  wire logic [mts_pkg::DATA_W-1:0] above_d,
  input  wire logic [mts_pkg::DATA_W-1:0] below_d,
  output logic      [mts_pkg::DATA_W-1:0] q
);
  import mts_pkg::*;

  logic [DATA_W-1:0] data_r;
  logic [DATA_W-1:0] data_nxt;

  always_comb begin
    data_nxt = data_r;
    if (ctl.push) begin
      data_nxt = above_d;
    end else if (ctl.pop) begin
      data_nxt = below_d;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign q = data_r;
endmodule
`default_nettype wire

>>> hdl/mts_lane.sv
// Row of stack cells; cell 0 is the top of the stack.
`default_nettype none
module mts_lane (
  input  wire logic                       clk,
  input  wire mts_pkg::shift_ctl_t        ctl,
  input  wire logic [mts_pkg::DATA_W-1:0] push_data,
  output logic      [mts_pkg::DATA_W-1:0] top0,
  output logic      [mts_pkg::DATA_W-1:0] top1
);
  import mts_pkg::*;

  logic [DATA_W-1:0] cell_q [STACK_DEPTH];

  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    logic [DATA_W-1:0] above_d;
    logic [DATA_W-1:0] below_d;

    if (i == 0) begin : g_top
      assign above_d = push_data;
    end else begin : g_mid
      assign above_d = cell_q[i-1];
    end

    // bottom cell refills with its own value; that entry is beyond the count
    if (i == STACK_DEPTH - 1) begin : g_bot
      assign below_d = cell_q[i];
    end else begin : g_inner
      assign below_d = cell_q[i+1];
    end

    mts_cell u_cell (
      .clk     (clk),
      .ctl     (ctl),
      .above_d (above_d),
      .below_d (below_d),
      .q       (cell_q[i])
    );
  end

  assign top0 = cell_q[0];
  assign top1 = cell_q[1];
endmodule
`default_nettype wire

>>> hdl/min_tracking_stack_unit.sv
// Top level of the min tracking stack: control, counts and result register.
`default_nettype none
// LIFO stack of signed 32-bit words that also tracks its running minimum.
// Each input word is a push (in_tuser = 0) of in_tdata or a pop (in_tuser = 1).
// Exactly one result word follows every input word, giving the top entry and
// the smallest entry held after the operation (both 32'h7FFF_FFFF when the
// stack is empty), an empty flag and a flag for a push dropped on a full
// stack. A pop on an empty stack changes nothing. Throughput is one word per
// clock: the stack is a row of 256 shift cells for values and a second row for
// the minimum history, so a push or pop is a single parallel shift, and the
// top two cells of each row give every result without a memory read. The
// result register sets out_tvalid in the cycle after input acceptance; it lets a
// new word enter while the previous result waits, so the input stalls only
// while a result is held and out_tready is low. No clearing pass after reset.
module min_tracking_stack_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input channel
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,   // [31:0] push_value
  input  wire logic        in_tuser,   // [0] req_type
  // result channel
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic      [63:0] out_tdata,  // [31:0] top_value, [63:32] min_value
  output logic      [1:0]  out_tuser   // [0] is_empty, [1] push_refused
);
  import mts_pkg::*;

  // entry counts of both rows
  logic [CNT_W-1:0]  vcnt_r, vcnt_nxt;
  logic [CNT_W-1:0]  mcnt_r, mcnt_nxt;

  // result register
  logic              out_valid_r, out_valid_nxt;
  logic [DATA_W-1:0] top_r, top_nxt;
  logic [DATA_W-1:0] min_r, min_nxt;
  logic              empty_r, empty_nxt;
  logic              refused_r, refused_nxt;

  logic              accept;
  logic              v_empty, v_full, m_empty;
  shift_ctl_t        vctl, mctl;
  logic [DATA_W-1:0] v0, v1, m0, m1;

  assign in_tready = !out_valid_r || out_tready;
  assign accept    = in_tvalid && in_tready;

  assign v_empty = (vcnt_r == '0);
  assign v_full  = (vcnt_r == CNT_W'(STACK_DEPTH));
  assign m_empty = (mcnt_r == '0);

  always_comb begin
    vctl        = '0;
    mctl        = '0;
    refused_nxt = 1'b0;
    vcnt_nxt    = vcnt_r;
    mcnt_nxt    = mcnt_r;

    if (accept) begin
      if (in_tuser == REQ_PUSH) begin
        if (v_full) begin
          // drop the word, flag it
          refused_nxt = 1'b1;
        end else begin
          vctl.push = 1'b1;
          // ties go on the minimum row too so duplicates pop correctly
          if (m_empty || ($signed(in_tdata) <= $signed(m0))) begin
            mctl.push = 1'b1;
          end
        end
      end else if (!v_empty) begin
        vctl.pop = 1'b1;
        if (!m_empty && (m0 == v0)) begin
          mctl.pop = 1'b1;
        end
      end
    end

    if (vctl.push) begin
      vcnt_nxt = vcnt_r + CNT_W'(1);
    end else if (vctl.pop) begin
      vcnt_nxt = vcnt_r - CNT_W'(1);
    end
    if (mctl.push) begin
      mcnt_nxt = mcnt_r + CNT_W'(1);
    end else if (mctl.pop) begin
      mcnt_nxt = mcnt_r - CNT_W'(1);
    end
  end

  // Results after the operation, taken from the top two cells of each row
  always_comb begin
    if (vctl.push) begin
      top_nxt = in_tdata;
    end else if (vcnt_nxt == '0) begin
      top_nxt = INT_MAX;
    end else if (vctl.pop) begin
      top_nxt = v1;
    end else begin
      top_nxt = v0;
    end

    if (mctl.push) begin
      min_nxt = in_tdata;
    end else if (mcnt_nxt == '0) begin
      min_nxt = INT_MAX;
    end else if (mctl.pop) begin
      min_nxt = m1;
    end else begin
      min_nxt = m0;
    end

    empty_nxt = (vcnt_nxt == '0);

    // hold a pending result until taken, load on each accepted word
    if (accept) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  mts_lane u_vlane (
    .clk       (clk),
    .ctl       (vctl),
    .push_data (in_tdata),
    .top0      (v0),
    .top1      (v1)
  );

  mts_lane u_mlane (
    .clk       (clk),
    .ctl       (mctl),
    .push_data (in_tdata),
    .top0      (m0),
    .top1      (m1)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vcnt_r      <= '0;
      mcnt_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      vcnt_r      <= vcnt_nxt;
      mcnt_r      <= mcnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      top_r     <= top_nxt;
      min_r     <= min_nxt;
      empty_r   <= empty_nxt;
      refused_r <= refused_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {min_r, top_r};
  assign out_tuser  = {refused_r, empty_r};
endmodule
`default_nettype wire

>>> hdl/mts_checker.sv
// Port-level checks of the min tracking stack and their bind.
`default_nettype none
`include "min_tracking_stack_unit_macros.svh"
module mts_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [63:0] out_tdata,
  input wire logic [1:0]  out_tuser
);
  import mts_pkg::*;

  // an accepted word always yields a result next cycle
  `MTS_ASSERT(a_result_follows, in_tvalid && in_tready |=> out_tvalid, "accepted word gave no result")
  // an empty stack reports the largest value for both top and minimum
  `MTS_ASSERT(a_empty_max, out_tvalid && out_tuser[0] |-> (out_tdata[31:0] == INT_MAX) && (out_tdata[63:32] == INT_MAX), "empty stack must report max values")
  // the minimum never exceeds the top, and a refused push never reports an empty stack
  `MTS_ASSERT(a_min_le_top, out_tvalid && !out_tuser[0] |-> ($signed(out_tdata[63:32]) <= $signed(out_tdata[31:0])) && !(out_tuser[1] && out_tuser[0]), "minimum above top or refused on empty")
  // a stalled result holds
  `MTS_ASSERT(a_stall_hold, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser), "stalled result changed")
endmodule

bind min_tracking_stack_unit mts_checker u_mts_checker (.*);
`default_nettype wire

>>> test/mts_result_checker.sv
// Scoreboard for the min tracking stack: predicts each result word and compares it.
module mts_result_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [31:0] in_tdata,
  input  logic        in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [63:0] out_tdata,
  input  logic [1:0]  out_tuser,
  output int          fail_count,
  output int          pending_count,
  output int          results_checked,
  output int          refused_seen,
  output int          empty_pops,
  output int          peak_depth
);
  import mts_pkg::*;

  typedef struct packed {
    logic signed [DATA_W-1:0] top;
    logic signed [DATA_W-1:0] minimum;
    logic                     empty;
    logic                     refused;
  } stack_view_t;

  logic signed [DATA_W-1:0] value_mem [STACK_DEPTH];
  logic signed [DATA_W-1:0] min_mem   [STACK_DEPTH];
  int                       value_cnt;
  int                       min_cnt;
  stack_view_t              expected_views [$];

  // Apply one push or pop to the shadow stacks and return what the block should show.
  function automatic stack_view_t apply_request(logic op, logic signed [DATA_W-1:0] val);
    stack_view_t view;
    view.refused = 1'b0;
    if (op == REQ_PUSH) begin
      if (value_cnt == STACK_DEPTH) begin
        view.refused = 1'b1;
      end else begin
        value_mem[value_cnt] = val;
        value_cnt++;
        if (min_cnt == 0 || val <= min_mem[min_cnt-1]) begin
          min_mem[min_cnt] = val;
          min_cnt++;
        end
      end
    end else if (value_cnt > 0) begin
      if (min_cnt > 0 && min_mem[min_cnt-1] == value_mem[value_cnt-1])
        min_cnt--;
      value_cnt--;
    end
    view.top     = (value_cnt > 0) ? value_mem[value_cnt-1] : INT_MAX;
    view.minimum = (min_cnt > 0) ? min_mem[min_cnt-1] : INT_MAX;
    view.empty   = (value_cnt == 0);
    return view;
  endfunction

  always @(posedge clk) begin
    stack_view_t want;
    stack_view_t got;
    if (!rst_n) begin
      value_cnt = 0;
      min_cnt = 0;
      expected_views.delete();
      fail_count = 0;
      results_checked = 0;
      refused_seen = 0;
      empty_pops = 0;
      peak_depth = 0;
    end else begin
      // Compare the result first: it always belongs to an earlier input word.
      if (out_tvalid && out_tready) begin
        got.top     = out_tdata[31:0];
        got.minimum = out_tdata[63:32];
        got.empty   = out_tuser[0];
        got.refused = out_tuser[1];
        if (expected_views.size() == 0) begin
          $error("result word with nothing expected: top %0d min %0d",
                 got.top, got.minimum);
          fail_count++;
        end else begin
          want = expected_views.pop_front();
          results_checked++;
          if (got.top !== want.top) begin
            $error("top_value: expected %0d, got %0d", want.top, got.top);
            fail_count++;
          end
          if (got.minimum !== want.minimum) begin
            $error("min_value: expected %0d, got %0d", want.minimum, got.minimum);
            fail_count++;
          end
          if (got.empty !== want.empty) begin
            $error("is_empty: expected %0b, got %0b", want.empty, got.empty);
            fail_count++;
          end
          if (got.refused !== want.refused) begin
            $error("push_refused: expected %0b, got %0b", want.refused, got.refused);
            fail_count++;
          end
        end
      end
      if (in_tvalid && in_tready) begin
        if (in_tuser == REQ_POP && value_cnt == 0)
          empty_pops++;
        want = apply_request(in_tuser, in_tdata);
        if (want.refused)
          refused_seen++;
        if (value_cnt > peak_depth)
          peak_depth = value_cnt;
        expected_views.push_back(want);
      end
    end
    pending_count = expected_views.size();
  end

endmodule

>>> test/tb_min_tracking_stack_unit.sv
// Testbench top for the min tracking stack: stimulus, watchdog and verdict.
module tb_min_tracking_stack_unit;
  import mts_pkg::*;

  // Give up after this many cycles in which neither channel moves a word.
  localparam int IDLE_LIMIT = 1000;
  // Length of the long receiver hold-off that backs the block up.
  localparam int HOLD_CYCLES = 48;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;   // [31:0] push_value
  logic        in_tuser;   // [0] req_type
  logic        out_tvalid;
  logic        out_tready;
  logic [63:0] out_tdata;  // [31:0] top_value, [63:32] min_value
  logic [1:0]  out_tuser;  // [0] is_empty, [1] push_refused

  int fail_count;
  int pending_count;
  int results_checked;
  int refused_seen;
  int empty_pops;
  int peak_depth;

  // Stimulus bookkeeping only: how deep the stack should be, to steer the sequences.
  int stack_depth;
  int push_words;
  int pop_words;
  int idle_cycles;
  bit calm;      // no idling on either side
  bit hold_req;  // ask the receiver for its long hold-off

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  min_tracking_stack_unit u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  mts_result_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .in_tuser       (in_tuser),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .out_tuser      (out_tuser),
    .fail_count     (fail_count),
    .pending_count  (pending_count),
    .results_checked(results_checked),
    .refused_seen   (refused_seen),
    .empty_pops     (empty_pops),
    .peak_depth     (peak_depth)
  );

  // Draw a push value: often a narrow pool so that ties with the minimum are
  // frequent, some extremes and powers of two, the rest across the full signed range.
  function automatic logic [31:0] pick_value();
    logic [31:0] v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: v = $urandom_range(0, 15) - 8;
      4: v = 32'h8000_0000;
      5: v = INT_MAX;
      6: v = {31'b0, 1'b1} << $urandom_range(0, 31);
      default: v = $urandom();
    endcase
    return v;
  endfunction

  // Offer one word at a falling edge and hold it until the block takes it.
  // Leave valid high on return so the next word follows without a bubble.
  task automatic send_word(input logic op, input logic [31:0] val);
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= val;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
    if (op == REQ_PUSH) begin
      push_words++;
      if (stack_depth < STACK_DEPTH)
        stack_depth++;
    end else begin
      pop_words++;
      if (stack_depth > 0)
        stack_depth--;
    end
  endtask

  // Receiver: random stalls, one long hold-off on request,
  // and a steady ready once the run turns calm.
  initial begin
    bit hold_done;
    hold_done  = 1'b0;
    out_tready = 1'b0;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      if (!calm && hold_req && !hold_done) begin
        out_tready <= 1'b0;
        hold_done = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else if (!calm && $urandom_range(0, 4) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 4)) @(negedge clk);
      end else begin
        out_tready <= 1'b1;
        @(negedge clk);
      end
    end
  end

  // Watchdog: count cycles with no word moving on either channel.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles + 1 >= IDLE_LIMIT) begin
        $display("timeout: no word moved for %0d cycles", IDLE_LIMIT);
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  initial begin
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tuser    = REQ_PUSH;
    in_tdata    = '0;
    idle_cycles = 0;
    stack_depth = 0;
    push_words  = 0;
    pop_words   = 0;
    calm        = 1'b0;
    hold_req    = 1'b0;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: pop on an empty stack, extremes of the value range,
    // duplicate minimums popping one at a time, a non-minimum push,
    // and draining back to empty.
    send_word(REQ_POP,  $urandom());
    send_word(REQ_PUSH, INT_MAX);
    send_word(REQ_PUSH, 32'h8000_0000);
    send_word(REQ_PUSH, 32'h8000_0000);
    send_word(REQ_PUSH, 32'h0000_0000);
    send_word(REQ_PUSH, 32'hFFFF_FFFF);
    send_word(REQ_POP,  32'hFFFF_FFFF);
    send_word(REQ_POP,  $urandom());
    send_word(REQ_POP,  $urandom());
    send_word(REQ_POP,  $urandom());
    send_word(REQ_POP,  $urandom());
    send_word(REQ_POP,  $urandom());
    send_word(REQ_PUSH, 32'd5);
    send_word(REQ_PUSH, 32'd7);
    send_word(REQ_PUSH, 32'd5);
    send_word(REQ_PUSH, 32'd3);
    send_word(REQ_POP,  $urandom());
    send_word(REQ_POP,  $urandom());
    send_word(REQ_POP,  $urandom());
    send_word(REQ_POP,  $urandom());
    send_word(REQ_PUSH, 32'h8000_0001);
    send_word(REQ_PUSH, 32'h7FFF_FFFE);
    send_word(REQ_POP,  $urandom());
    send_word(REQ_POP,  $urandom());

    // Mixed pushes and pops near the bottom; request the long hold-off here
    // so the block backs up and drops in_tready while words keep coming.
    hold_req = 1'b1;
    repeat (80)
      send_word(($urandom_range(0, 99) < 55) ? REQ_PUSH : REQ_POP, pick_value());

    // Fill to the top with mostly pushes, then push into a full stack.
    while (stack_depth < STACK_DEPTH)
      send_word(($urandom_range(0, 19) == 0) ? REQ_POP : REQ_PUSH, pick_value());
    repeat (3) send_word(REQ_PUSH, pick_value());
    send_word(REQ_POP,  pick_value());
    send_word(REQ_PUSH, pick_value());
    send_word(REQ_PUSH, pick_value());

    // Drain with mostly pops, then pop past empty.
    while (stack_depth > 0)
      send_word(($urandom_range(0, 19) == 0) ? REQ_PUSH : REQ_POP, pick_value());
    repeat (2) send_word(REQ_POP, pick_value());

    // Back-to-back tail: no idling on either side.
    calm = 1'b1;
    repeat (60)
      send_word(($urandom_range(0, 1) == 0) ? REQ_PUSH : REQ_POP, pick_value());
    in_tvalid <= 1'b0;

    // Wait for every result, then a few cycles more for anything stray.
    while (pending_count != 0) @(negedge clk);
    repeat (8) @(negedge clk);

    $display("Sent %0d pushes and %0d pops: directed, mixed, fill and drain, calm tail.",
             push_words, pop_words);
    $display("Checked %0d results: %0d refused pushes, %0d empty pops, peak depth %0d.",
             results_checked, refused_seen, empty_pops, peak_depth);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
